@@ design/pcg_pkg.sv @@
// Shared types, constants and a helper function of the PCG32 random number generator.
package pcg_pkg;

   // LCG multiplier, split into 32-bit halves for the shared 32x32 multiplier.
   localparam logic [63:0] PCG_MULT      = 64'd6364136223846793005;
   localparam logic [31:0] PCG_MULT_LO   = PCG_MULT[31:0];
   localparam logic [31:0] PCG_MULT_HI   = PCG_MULT[63:32];

   // State after reset: one draw taken from the reseeded state with zero registers.
   localparam logic [63:0] STATE_RESET   = 64'd6364136223846793006;
   localparam logic [63:0] INCR_RESET    = 64'd1;

   localparam int SEED_WIDTH      = 64;
   localparam int STREAM_WIDTH    = 63;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int BOUND_WIDTH     = 33;
   localparam int VALUE_WIDTH     = 32;
   localparam int FRACTION_WIDTH  = 53;

   // Request codes.
   typedef enum logic [1:0] {
      CMD_RAW      = 2'd0,
      CMD_BOUNDED  = 2'd1,
      CMD_FRACTION = 2'd2,
      CMD_RESEED   = 2'd3
   } command_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SEED   = 1'd0,
      CSR_STREAM = 1'd1
   } csr_index_type;

   // Steps of one draw: multiply low halves, then the two cross products, then update.
   typedef enum logic [2:0] {
      STEP_NONE,
      STEP_M0,
      STEP_M1,
      STEP_M2,
      STEP_M3
   } step_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RESEED,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_THR_START,
      ST_THR_WAIT,
      ST_MOD_START,
      ST_MOD_WAIT,
      ST_PUBLISH
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     accept;
      logic     res_clear;
      logic     set_error;
      step_type step;
      logic     reseed_load;
      logic     thr_start;
      logic     thr_load;
      logic     mod_start;
      logic     value_from_draw;
      logic     value_from_rem;
      logic     frac_hi_load;
      logic     frac_lo_load;
      logic     publish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      command_type command;
      logic        bound_bad;
      logic        bound_full;
      logic        draw_ok;
      logic        div_done;
   } dpath_sts_type;

   // XSH-RR output permutation of a 64-bit state.
   function automatic logic [31:0] pcg_output(input logic [63:0] s);
      logic [63:0] mixed;
      logic [31:0] xs;
      logic [4:0]  rot;
      logic [63:0] doubled;
      mixed   = ((s >> 18) ^ s) >> 27;
      xs      = mixed[31:0];
      rot     = s[63:59];
      doubled = {xs, xs} >> rot;
      return doubled[31:0];
   endfunction

endpackage

@@ design/pcg32_random_generator.sv @@
// Top level of the PCG32 XSH-RR random number generator.
//
// One request is in progress at a time; the result sits in an output register, so the
// next request is taken while a result still waits. Each draw runs in steps on the
// one shared 32x32 multiplier (low product, two cross products, state update). A
// raw request takes one draw, a unit fraction two, a reseed one after loading the
// state, and a bad bound none, its result carrying an error status. A bounded draw runs
// a bit-serial threshold remainder pass, draws until a draw is accepted, then a final
// modulo pass; a bound of 2^32 takes a single draw and no remainder pass.
// Configuration writes take effect at the next reseed request.
module pcg32_random_generator
   import pcg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   input  logic [BOUND_WIDTH-1:0]     req_bound,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [VALUE_WIDTH-1:0]     rsp_value,
   output logic [FRACTION_WIDTH-1:0]  rsp_fraction,
   output logic                       rsp_status
);

   ctrl_cmd_type  cmd;
   dpath_sts_type sts;

   pcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcg_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_command      (req_command),
      .req_bound        (req_bound),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_value        (rsp_value),
      .rsp_fraction     (rsp_fraction),
      .rsp_status       (rsp_status)
   );

endmodule

@@ design/pcg_div.sv @@
// Bit-serial restoring remainder unit: 32-bit dividend modulo a 32-bit divisor.
module pcg_div
   import pcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] remainder,
   output logic        done
);

   logic [31:0] quot_ff,  quot_in;
   logic [31:0] rem_ff,   rem_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff,  busy_in;
   logic        done_ff,  done_in;
   logic [32:0] trial;
   logic [32:0] diff;

   // One dividend bit enters the partial remainder each cycle while a pass runs.
   always_comb begin
      trial    = {rem_ff, quot_ff[31]};
      diff     = trial - {1'b0, divisor};
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in  = {quot_ff[30:0], 1'b0};
         rem_in   = (trial >= {1'b0, divisor}) ? diff[31:0] : trial[31:0];
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers are cleared by reset; the data registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

   // The finish pulse only ends a running pass, and a pass is never restarted midway.
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder finished without a running pass");
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder pass started while busy");

endmodule

@@ design/pcg_dpath.sv @@
// Datapath: generator state, shared multiplier, remainder unit, work and result registers.
module pcg_dpath
   import pcg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data,
   input  logic [1:0]                 req_command,
   input  logic [BOUND_WIDTH-1:0]     req_bound,
   input  ctrl_cmd_type               cmd,
   output dpath_sts_type              sts,
   output logic [VALUE_WIDTH-1:0]     rsp_value,
   output logic [FRACTION_WIDTH-1:0]  rsp_fraction,
   output logic                       rsp_status
);

   logic [SEED_WIDTH-1:0]     seed_ff;
   logic [STREAM_WIDTH-1:0]   stream_ff;
   logic [63:0]               state_ff,  state_in;
   logic [63:0]               incr_ff,   incr_in;
   logic [63:0]               acc_ff,    acc_in;
   logic [63:0]               prod_ff,   prod_in;
   logic [31:0]               draw_ff,   draw_in;
   logic [31:0]               thr_ff;
   logic [1:0]                command_ff;
   logic [BOUND_WIDTH-1:0]    bound_ff;
   logic [VALUE_WIDTH-1:0]    value_w_ff, value_w_in;
   logic [FRACTION_WIDTH-1:0] frac_w_ff,  frac_w_in;
   logic                      status_w_ff, status_w_in;
   logic [VALUE_WIDTH-1:0]    rsp_value_ff;
   logic [FRACTION_WIDTH-1:0] rsp_fraction_ff;
   logic                      rsp_status_ff;
   logic [31:0]               mul_a, mul_b;
   logic [63:0]               prod_shifted;
   logic [63:0]               incr_new;
   logic                      div_start;
   logic [31:0]               div_dividend;
   logic [31:0]               div_rem;
   logic                      div_done;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         stream_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SEED:   seed_ff   <= csr_write_data;
            CSR_STREAM: stream_ff <= csr_write_data[STREAM_WIDTH-1:0];
            default:    ;
         endcase
      end
   end

   // Request fields are held for the whole request.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         command_ff <= req_command;
         bound_ff   <= req_bound;
      end
   end

   // Shared 32x32 multiplier; the operands follow the step of the draw.
   always_comb begin
      mul_a = state_ff[31:0];
      mul_b = PCG_MULT_LO;
      case (cmd.step)
         STEP_M1: begin
            mul_a = state_ff[63:32];
            mul_b = PCG_MULT_LO;
         end
         STEP_M2: begin
            mul_a = state_ff[31:0];
            mul_b = PCG_MULT_HI;
         end
         default: begin
            mul_a = state_ff[31:0];
            mul_b = PCG_MULT_LO;
         end
      endcase
   end

   assign prod_shifted = {prod_ff[31:0], 32'd0};
   assign incr_new     = {stream_ff, 1'b1};

   // State advance: state * mult + increment, built from three partial products.
   always_comb begin
      prod_in  = mul_a * mul_b;
      acc_in   = acc_ff;
      state_in = state_ff;
      incr_in  = incr_ff;
      draw_in  = draw_ff;
      case (cmd.step)
         STEP_M0: draw_in  = pcg_output(state_ff);
         STEP_M1: acc_in   = prod_ff + incr_ff;
         STEP_M2: acc_in   = acc_ff + prod_shifted;
         STEP_M3: state_in = acc_ff + prod_shifted;
         default: ;
      endcase
      // Reseed: the first draw from a zero state lands on the increment itself.
      if (cmd.reseed_load) begin
         incr_in  = incr_new;
         state_in = incr_new + seed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_RESET;
         incr_ff  <= INCR_RESET;
      end else begin
         state_ff <= state_in;
         incr_ff  <= incr_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      draw_ff <= draw_in;
   end

   // Remainder unit serves both the rejection threshold and the final modulo.
   assign div_start    = cmd.thr_start | cmd.mod_start;
   assign div_dividend = cmd.mod_start ? draw_ff : (32'd0 - bound_ff[31:0]);

   pcg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bound_ff[31:0]),
      .remainder (div_rem),
      .done      (div_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.thr_load) begin
         thr_ff <= div_rem;
      end
   end

   // Work registers collect the result while the request is in progress.
   always_comb begin
      value_w_in  = value_w_ff;
      frac_w_in   = frac_w_ff;
      status_w_in = status_w_ff;
      if (cmd.res_clear) begin
         value_w_in  = '0;
         frac_w_in   = '0;
         status_w_in = 1'b0;
      end
      if (cmd.set_error) begin
         status_w_in = 1'b1;
      end
      if (cmd.value_from_draw) begin
         value_w_in = draw_ff;
      end
      if (cmd.value_from_rem) begin
         value_w_in = div_rem;
      end
      if (cmd.frac_hi_load) begin
         frac_w_in[52:26] = draw_ff[31:5];
      end
      if (cmd.frac_lo_load) begin
         frac_w_in[25:0] = draw_ff[31:6];
      end
   end

   always_ff @(posedge clock) begin
      value_w_ff  <= value_w_in;
      frac_w_ff   <= frac_w_in;
      status_w_ff <= status_w_in;
   end

   // Output register: loaded only when the result slot is free.
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_value_ff    <= value_w_ff;
         rsp_fraction_ff <= frac_w_ff;
         rsp_status_ff   <= status_w_ff;
      end
   end

   assign rsp_value    = rsp_value_ff;
   assign rsp_fraction = rsp_fraction_ff;
   assign rsp_status   = rsp_status_ff;

   // Status toward the controller.
   always_comb begin
      sts.command    = command_type'(command_ff);
      sts.bound_bad  = (bound_ff == '0) || (bound_ff[32] && (|bound_ff[31:0]));
      sts.bound_full = bound_ff[32] && !(|bound_ff[31:0]);
      sts.draw_ok    = (draw_ff >= thr_ff);
      sts.div_done   = div_done;
   end

endmodule

@@ design/pcg_ctrl.sv @@
// Controller state machine: sequences draws, remainder passes and result transfers.
module pcg_ctrl
   import pcg_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dpath_sts_type sts,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           second_ff, second_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.command)
               CMD_RAW:      state_in = ST_M0;
               CMD_FRACTION: state_in = ST_M0;
               CMD_RESEED:   state_in = ST_RESEED;
               CMD_BOUNDED: begin
                  if (sts.bound_bad) begin
                     state_in = ST_PUBLISH;
                  end else if (sts.bound_full) begin
                     state_in = ST_M0;
                  end else begin
                     state_in = ST_THR_START;
                  end
               end
               default: state_in = ST_PUBLISH;
            endcase
         end
         ST_RESEED: state_in = ST_M0;
         ST_M0:     state_in = ST_M1;
         ST_M1:     state_in = ST_M2;
         ST_M2:     state_in = ST_M3;
         ST_M3: begin
            case (sts.command)
               CMD_BOUNDED: begin
                  if (sts.bound_full) begin
                     state_in = ST_PUBLISH;
                  end else if (sts.draw_ok) begin
                     state_in = ST_MOD_START;
                  end else begin
                     state_in = ST_M0;
                  end
               end
               CMD_FRACTION: state_in = second_ff ? ST_PUBLISH : ST_M0;
               default:      state_in = ST_PUBLISH;
            endcase
         end
         ST_THR_START: state_in = ST_THR_WAIT;
         ST_THR_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_M0;
            end
         end
         ST_MOD_START: state_in = ST_MOD_WAIT;
         ST_MOD_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd       = '0;
      cmd.step  = STEP_NONE;
      second_in = second_ff;
      case (state_ff)
         ST_IDLE:   cmd.accept = req_valid;
         ST_DECODE: begin
            cmd.res_clear = 1'b1;
            second_in     = 1'b0;
            if (sts.command == CMD_BOUNDED && sts.bound_bad) begin
               cmd.set_error = 1'b1;
            end
         end
         ST_RESEED: cmd.reseed_load = 1'b1;
         ST_M0:     cmd.step = STEP_M0;
         ST_M1:     cmd.step = STEP_M1;
         ST_M2:     cmd.step = STEP_M2;
         ST_M3: begin
            cmd.step = STEP_M3;
            case (sts.command)
               CMD_RAW: cmd.value_from_draw = 1'b1;
               CMD_BOUNDED: begin
                  if (sts.bound_full) begin
                     cmd.value_from_draw = 1'b1;
                  end
               end
               CMD_FRACTION: begin
                  if (second_ff) begin
                     cmd.frac_lo_load = 1'b1;
                  end else begin
                     cmd.frac_hi_load = 1'b1;
                     second_in        = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_THR_START: cmd.thr_start = 1'b1;
         ST_THR_WAIT:  cmd.thr_load  = sts.div_done;
         ST_MOD_START: cmd.mod_start = 1'b1;
         ST_MOD_WAIT:  cmd.value_from_rem = sts.div_done;
         ST_PUBLISH:   cmd.publish = slot_free;
         default: ;
      endcase
   end

   // Result valid: set by a publish, cleared by a completed transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // A new result never overwrites one still waiting, and each accepted request is decoded.
   a_publish_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result published over a pending one");
   a_publish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid_ff)
      else $error("published result not presented");
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted request not decoded");

endmodule
